// ----- rtl/core/ptb_pkg.sv -----
`timescale 1ns / 1ps
// ptb_pkg: shared types and constants for the periodic timer bank.
// No dependencies.
package ptb_pkg;

    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  now;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  granted_slot;
        logic               fired;
    } t_rsp;

    typedef struct packed {
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  due;
    } t_entry;

endpackage

// ----- rtl/core/ptb_stream_if.sv -----
`timescale 1ns / 1ps
// ptb_stream_if: valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface ptb_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ptb_ram.sv -----
`timescale 1ns / 1ps
// ptb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/periodic_timer_bank_core.sv -----
`timescale 1ns / 1ps
// periodic_timer_bank_core: top level of the periodic timer bank.
// Uses ptb_pkg, ptb_stream_if and ptb_ram.
//
// One request word is taken at a time and gives one response word. Free and
// query go from acceptance through S_FIN and back to ready. Allocate walks
// the used flags from slot 0 and claims the first free slot (none when the
// bank is full). Update walks every slot through the period/due RAM, whose
// single read port and the one add/compare unit handle one slot per cycle.
// A finished response sits in an output register while the next request is
// taken.
module periodic_timer_bank_core #(
    parameter int SLOTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptb_stream_if.sink    i_req,
    ptb_stream_if.source  o_rsp
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    ptb_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_issue, n_issue;
    logic            r_pipe_v, n_pipe_v;
    logic [IW-1:0]   r_pipe_idx, n_pipe_idx;
    ptb_pkg::t_req   r_req, n_req;
    ptb_pkg::t_rsp   r_res, n_res;
    ptb_pkg::t_rsp   r_out, n_out;
    logic            r_out_v, n_out_v;
    logic [SLOTS-1:0] r_used, n_used;
    logic [SLOTS-1:0] r_fired, n_fired;

    logic                         acc;
    logic                         slot_in_range;
    logic [IW-1:0]                req_idx;
    logic                         hit;
    logic [ptb_pkg::TIME_W-1:0]   addend;
    logic [ptb_pkg::TIME_W-1:0]   sum;
    logic                         we;
    logic [IW-1:0]                waddr;
    ptb_pkg::t_entry              wdata;
    ptb_pkg::t_entry              rdata;

    ptb_ram #(
        .WIDTH ($bits(ptb_pkg::t_entry)),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign i_req.ready   = (r_state == ptb_pkg::S_IDLE);
    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_out;

    assign acc           = i_req.valid && i_req.ready;
    assign slot_in_range = ({{(32 - ptb_pkg::SLOT_W){1'b0}}, i_req.payload.slot} < 32'(SLOTS));
    assign req_idx       = IW'(i_req.payload.slot);

    // shared add/compare unit
    assign addend = (r_state == ptb_pkg::S_ALLOC) ? r_req.period : rdata.period;
    assign sum    = r_req.now + addend;
    assign hit    = r_used[r_pipe_idx] && (r_req.now >= rdata.due);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptb_pkg::S_IDLE: begin
                if (acc) begin
                    case (i_req.payload.op) inside
                        ptb_pkg::OP_ALLOC:                   n_state = ptb_pkg::S_ALLOC;
                        ptb_pkg::OP_UPDATE:                  n_state = ptb_pkg::S_UPD;
                        ptb_pkg::OP_FREE, ptb_pkg::OP_QUERY: n_state = ptb_pkg::S_FIN;
                        default:                             n_state = ptb_pkg::S_FIN;
                    endcase
                end
            end
            ptb_pkg::S_ALLOC: begin
                if (!r_used[r_idx] || (r_idx == LAST)) begin
                    n_state = ptb_pkg::S_FIN;
                end
            end
            ptb_pkg::S_UPD: begin
                if (r_pipe_v && !r_issue) begin
                    n_state = ptb_pkg::S_FIN;
                end
            end
            ptb_pkg::S_FIN: begin
                if (!r_out_v || o_rsp.ready) begin
                    n_state = ptb_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_pipe_v   = r_pipe_v;
        n_pipe_idx = r_pipe_idx;
        n_req      = r_req;
        n_res      = r_res;
        n_out      = r_out;
        n_out_v    = r_out_v;
        n_used     = r_used;
        n_fired    = r_fired;
        we         = 1'b0;
        waddr      = r_idx;
        wdata      = '{period: r_req.period, due: sum};

        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            ptb_pkg::S_IDLE: begin
                if (acc) begin
                    n_req    = i_req.payload;
                    n_idx    = '0;
                    n_issue  = 1'b1;
                    n_pipe_v = 1'b0;
                    n_res    = '{ok: 1'b1, granted_slot: '0, fired: 1'b0};
                    if (slot_in_range && (i_req.payload.op == ptb_pkg::OP_FREE)) begin
                        n_used[req_idx] = 1'b0;
                    end
                    if (slot_in_range && (i_req.payload.op == ptb_pkg::OP_QUERY)) begin
                        n_res.fired = r_fired[req_idx];
                    end
                end
            end
            ptb_pkg::S_ALLOC: begin
                if (!r_used[r_idx]) begin
                    n_used[r_idx]      = 1'b1;
                    we                 = 1'b1;
                    n_res.granted_slot = ptb_pkg::SLOT_W'(r_idx);
                end else if (r_idx == LAST) begin
                    n_res.ok = 1'b0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ptb_pkg::S_UPD: begin
                // read slot r_idx while slot r_pipe_idx is compared and, on a hit, written
                n_pipe_v   = r_issue;
                n_pipe_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                if (r_pipe_v) begin
                    n_fired[r_pipe_idx] = hit;
                    if (hit) begin
                        we    = 1'b1;
                        waddr = r_pipe_idx;
                        wdata = '{period: rdata.period, due: sum};
                    end
                end
            end
            ptb_pkg::S_FIN: begin
                if (!r_out_v || o_rsp.ready) begin
                    n_out   = r_res;
                    n_out_v = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptb_pkg::S_IDLE;
            r_issue  <= 1'b0;
            r_pipe_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_used   <= '0;
            r_fired  <= '0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_pipe_v <= n_pipe_v;
            r_out_v  <= n_out_v;
            r_used   <= n_used;
            r_fired  <= n_fired;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pipe_idx <= n_pipe_idx;
        r_req      <= n_req;
        r_res      <= n_res;
        r_out      <= n_out;
    end

`ifndef SYNTH
    a_fail_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptb_pkg::S_FIN && !r_res.ok) |-> (&r_used))
        else $error("allocate failed with a free slot");

    a_grant_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptb_pkg::S_FIN && r_req.op == ptb_pkg::OP_ALLOC && r_res.ok)
        |-> r_used[r_idx])
        else $error("granted slot not marked used");

    a_pipe_only_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_v |-> (r_state == ptb_pkg::S_UPD))
        else $error("update compare stage active outside update walk");
`endif
endmodule
